// ----- hdl/fct_pkg.sv -----
// Package for the frustum cull tester: widths, command and verdict codes,
// and the item record that travels down the plane cell chain.
// No dependencies.
`timescale 1ns / 1ps

package fct_pkg;

    // Configuration port
    localparam int CFG_N     = 6;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 64;

    // Number of plane cells in the chain
    localparam int PLANE_N = CFG_N;

    // Datapath widths: corner coordinate, coefficient product, plane value
    localparam int COORD_W = 17;
    localparam int PROD_W  = 33;
    localparam int VAL_W   = 36;

    // Test commands
    localparam logic [2:0] CMD_POINT    = 3'd0;
    localparam logic [2:0] CMD_SPHERE   = 3'd1;
    localparam logic [2:0] CMD_CUBE     = 3'd2;
    localparam logic [2:0] CMD_BOX      = 3'd3;
    localparam logic [2:0] CMD_CLASSIFY = 3'd4;

    // Verdict codes
    localparam logic [1:0] VERD_OUT   = 2'd0;
    localparam logic [1:0] VERD_IN    = 2'd1;
    localparam logic [1:0] VERD_ISECT = 2'd2;

    // Item carried from cell to cell
    typedef struct packed {
        logic [2:0]                 cmd;
        logic [14:0]                extent;
        logic signed [COORD_W-1:0]  lo_x;
        logic signed [COORD_W-1:0]  lo_y;
        logic signed [COORD_W-1:0]  lo_z;
        logic signed [COORD_W-1:0]  hi_x;
        logic signed [COORD_W-1:0]  hi_y;
        logic signed [COORD_W-1:0]  hi_z;
        logic                       fail;
        logic                       any_out;
    } t_item;

endpackage

// ----- hdl/fct_if.sv -----
// Channel interfaces of the frustum cull tester: test items in, verdicts out.
// Depends on nothing.
`timescale 1ns / 1ps

interface fct_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         cmd;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    logic signed [15:0] bx;
    logic signed [15:0] by;
    logic signed [15:0] bz;
    logic [14:0]        extent;

    modport source (output valid, cmd, ax, ay, az, bx, by, bz, extent, input ready);
    modport sink   (input valid, cmd, ax, ay, az, bx, by, bz, extent, output ready);
endinterface

interface fct_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] verdict;

    modport source (output valid, verdict, input ready);
    modport sink   (input valid, verdict, output ready);
endinterface

// ----- hdl/fct_cell.sv -----
// One plane cell of the cull chain: holds one plane, evaluates the eight
// box corners against it in two stages and hands the item to the next cell.
// Depends on fct_pkg.
`timescale 1ns / 1ps

module fct_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_cfg_sel,
    input  logic [fct_pkg::CFG_W-1:0]  i_cfg_data,
    input  logic                       i_valid,
    input  fct_pkg::t_item             i_item,
    output logic                       o_valid,
    output fct_pkg::t_item             o_item
);
    import fct_pkg::*;

    logic [CFG_W-1:0]         r_plane;
    logic signed [15:0]       w_a, w_b, w_c, w_d;

    logic                     r_a_valid;
    t_item                    r_a_item;
    logic signed [PROD_W-1:0] r_plx, r_phx, r_ply, r_phy, r_plz, r_phz;
    logic signed [PROD_W-1:0] n_plx, n_phx, n_ply, n_phy, n_plz, n_phz;

    logic                     r_b_valid;
    t_item                    r_b_item;
    t_item                    n_b_item;

    logic signed [VAL_W-1:0]  w_d256;
    logic signed [VAL_W-1:0]  w_v [8];
    logic                     w_in [8];
    logic signed [VAL_W:0]    w_sph;
    logic                     w_any_in, w_any_out, w_fail_here;

    assign w_a = r_plane[15:0];
    assign w_b = r_plane[31:16];
    assign w_c = r_plane[47:32];
    assign w_d = r_plane[63:48];

    // Hold this cell's plane
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane <= '0;
        end else if (i_cfg_sel) begin
            r_plane <= i_cfg_data;
        end
    end

    // Stage A: the six coefficient products, low and high on each axis
    always_comb begin
        n_plx = w_a * i_item.lo_x;
        n_phx = w_a * i_item.hi_x;
        n_ply = w_b * i_item.lo_y;
        n_phy = w_b * i_item.hi_y;
        n_plz = w_c * i_item.lo_z;
        n_phz = w_c * i_item.hi_z;
    end

    // Stage B: sum the eight corners and update the verdict flags
    assign w_d256 = VAL_W'(w_d) <<< 8;

    always_comb begin
        w_any_in  = 1'b0;
        w_any_out = 1'b0;
        for (int k = 0; k < 8; k++) begin
            w_v[k] = VAL_W'(k[0] ? r_phx : r_plx)
                   + VAL_W'(k[1] ? r_phy : r_ply)
                   + VAL_W'(k[2] ? r_phz : r_plz)
                   + w_d256;
            if (k == 0 && r_a_item.cmd == CMD_CLASSIFY) begin
                w_in[k] = !w_v[k][VAL_W-1];
            end else begin
                w_in[k] = !w_v[k][VAL_W-1] && (w_v[k] != '0);
            end
            w_any_in  = w_any_in | w_in[k];
            w_any_out = w_any_out | !w_in[k];
        end

        // Sphere: the center value must clear minus the radius
        w_sph = (VAL_W+1)'(w_v[0]) + $signed({14'b0, r_a_item.extent, 8'b0});

        case (r_a_item.cmd)
            CMD_POINT:  w_fail_here = w_v[0][VAL_W-1] || (w_v[0] == '0);
            CMD_SPHERE: w_fail_here = w_sph[VAL_W] || (w_sph == '0);
            default:    w_fail_here = !w_any_in;
        endcase

        n_b_item         = r_a_item;
        n_b_item.fail    = r_a_item.fail | w_fail_here;
        n_b_item.any_out = r_a_item.any_out | w_any_out;
    end

    // Advance both stages together with the rest of the chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_item <= i_item;
            r_plx    <= n_plx;
            r_phx    <= n_phx;
            r_ply    <= n_ply;
            r_phy    <= n_phy;
            r_plz    <= n_plz;
            r_phz    <= n_phz;
            r_b_item <= n_b_item;
        end
    end

    assign o_valid = r_b_valid;
    assign o_item  = r_b_item;

endmodule

// ----- hdl/frustum_cull_tester.sv -----
// Top level of the frustum cull tester: entry stage, chain of six plane
// cells and the verdict register.
// Depends on fct_pkg, fct_if and fct_cell.
`timescale 1ns / 1ps

// Usage
// - i_in carries one test item (cmd, corner a, corner b, extent); a transfer
//   happens when valid and ready are both high. o_out carries one verdict
//   per item, in item order, with the same handshake.
// - Planes are loaded through i_cfg_we / i_cfg_idx / i_cfg_data, one 64-bit
//   plane per index (right, left, bottom, top, far, near). Load only while
//   no item is in flight; indexes past the last plane are ignored.
// - o_out.valid rises once the item has passed 14 registers: one entry stage
//   forming the corner bounds, two stages in each of the six plane cells
//   (products, then corner sums and flags), and one output register.
// - Throughput is one item per cycle while the receiver takes verdicts;
//   each plane cell runs its six products and eight corner sums every cycle.
// - When the receiver stalls with a verdict waiting, the whole chain holds
//   and i_in.ready drops; up to 14 items stay in flight.
// - Synchronous reset clears all planes to zero and empties the chain.
module frustum_cull_tester (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [fct_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [fct_pkg::CFG_W-1:0]     i_cfg_data,
    fct_in_if.sink                        i_in,
    fct_out_if.source                     o_out
);
    import fct_pkg::*;

    logic                     w_en;
    logic                     r_e_valid;
    t_item                    r_e_item;
    t_item                    n_e_item;
    logic signed [COORD_W-1:0] w_ext;

    logic                     w_valid [PLANE_N+1];
    t_item                    w_item  [PLANE_N+1];

    logic                     r_out_valid;
    logic [1:0]               r_verdict;
    logic [1:0]               n_verdict;

    // Whole chain advances unless a verdict waits on a stalled receiver
    assign w_en       = !r_out_valid || o_out.ready;
    assign i_in.ready = w_en;

    // Entry: form the low and high corner bounds per command
    assign w_ext = $signed({2'b0, i_in.extent});

    always_comb begin
        n_e_item         = '0;
        n_e_item.cmd     = i_in.cmd;
        n_e_item.extent  = i_in.extent;
        n_e_item.fail    = 1'b0;
        n_e_item.any_out = 1'b0;
        case (i_in.cmd)
            CMD_CUBE: begin
                n_e_item.lo_x = COORD_W'(i_in.ax) - w_ext;
                n_e_item.lo_y = COORD_W'(i_in.ay) - w_ext;
                n_e_item.lo_z = COORD_W'(i_in.az) - w_ext;
                n_e_item.hi_x = COORD_W'(i_in.ax) + w_ext;
                n_e_item.hi_y = COORD_W'(i_in.ay) + w_ext;
                n_e_item.hi_z = COORD_W'(i_in.az) + w_ext;
            end
            default: begin
                n_e_item.lo_x = COORD_W'(i_in.ax);
                n_e_item.lo_y = COORD_W'(i_in.ay);
                n_e_item.lo_z = COORD_W'(i_in.az);
                n_e_item.hi_x = COORD_W'(i_in.bx);
                n_e_item.hi_y = COORD_W'(i_in.by);
                n_e_item.hi_z = COORD_W'(i_in.bz);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
        end else if (w_en) begin
            r_e_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e_item <= n_e_item;
        end
    end

    assign w_valid[0] = r_e_valid;
    assign w_item[0]  = r_e_item;

    // Chain of plane cells
    for (genvar g = 0; g < PLANE_N; g++) begin : g_cell
        fct_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_en       (w_en),
            .i_cfg_sel  (i_cfg_we && (i_cfg_idx == CFG_IDX_W'(g))),
            .i_cfg_data (i_cfg_data),
            .i_valid    (w_valid[g]),
            .i_item     (w_item[g]),
            .o_valid    (w_valid[g+1]),
            .o_item     (w_item[g+1])
        );
    end

    // Resolve the verdict from the accumulated flags
    always_comb begin
        case (w_item[PLANE_N].cmd)
            CMD_POINT, CMD_SPHERE, CMD_CUBE, CMD_BOX:
                n_verdict = w_item[PLANE_N].fail ? VERD_OUT : VERD_IN;
            CMD_CLASSIFY:
                n_verdict = w_item[PLANE_N].fail    ? VERD_OUT :
                            w_item[PLANE_N].any_out ? VERD_ISECT : VERD_IN;
            default:
                n_verdict = VERD_OUT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_valid[PLANE_N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_verdict <= n_verdict;
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.verdict = r_verdict;

    // Checks
    a_reset_empty : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid && !r_e_valid)
        else $error("chain not emptied by reset");

    a_hold_on_stall : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_out.ready |=> r_out_valid && $stable(r_verdict))
        else $error("verdict lost under stall");

    a_verdict_code : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_verdict == VERD_OUT || r_verdict == VERD_IN ||
                         r_verdict == VERD_ISECT))
        else $error("undefined verdict code");

    a_ready_when_free : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> i_in.ready)
        else $error("input blocked with empty output register");

endmodule

// ----- test/frustum_cull_tester_tb.sv -----
// Self-checking bench for frustum_cull_tester: loads plane sets, streams culling tests
// with random handshake gaps and checks each verdict against a local predictor.
// Depends on fct_pkg, fct_if and frustum_cull_tester.
`timescale 1ns / 1ps

module frustum_cull_tester_tb;
    import fct_pkg::*;

    localparam int PIPE_LATENCY = 14;
    localparam int CYCLE_LIMIT  = 300000;

    // Register indexes of the plane port
    localparam logic [CFG_IDX_W-1:0] IDX_RIGHT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] IDX_LEFT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] IDX_BOTTOM = 3'd2;
    localparam logic [CFG_IDX_W-1:0] IDX_TOP    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] IDX_FAR    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] IDX_NEAR   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] IDX_SPARE6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] IDX_SPARE7 = 3'd7;

    // Command codes the block does not define
    localparam logic [2:0] CMD_UNDEF5 = 3'd5;
    localparam logic [2:0] CMD_UNDEF6 = 3'd6;
    localparam logic [2:0] CMD_UNDEF7 = 3'd7;

    // Q8.8 constants
    localparam logic [15:0] Q_ONE     = 16'h0100;
    localparam logic [15:0] Q_NEG_ONE = 16'hFF00;
    localparam logic [15:0] Q_ZERO    = 16'h0000;

    typedef struct packed {
        logic [2:0]         cmd;
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
        logic signed [15:0] bx;
        logic signed [15:0] by;
        logic signed [15:0] bz;
        logic [14:0]        extent;
    } t_cull_req;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_data;

    fct_in_if  in_if ();
    fct_out_if out_if ();

    frustum_cull_tester dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    // Local copy of the plane registers
    logic [63:0] planes [PLANE_N];

    t_cull_req   pending_reqs [$];
    logic [1:0]  verdict_q [$];
    t_cull_req   drv_req;
    logic        in_taken;
    int          issued_cnt;
    int          accepted_cnt;
    int          checked_cnt;
    int          fail_cnt;
    int          setup_cnt;
    int          cycle_cnt;
    int          src_gap;
    int          sink_stall;
    int          gap_pct;
    int          stall_pct;
    int          verd_seen [3];

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // ---------------------------------------------------------------- predictor

    function automatic longint plane_value(int p, longint x, longint y, longint z);
        logic [63:0] w;
        w = planes[p];
        return longint'($signed(w[15:0])) * x + longint'($signed(w[31:16])) * y
             + longint'($signed(w[47:32])) * z + longint'($signed(w[63:48])) * 256;
    endfunction

    // Corner k takes the high bound on x, y, z where bit 0, 1, 2 of k is set
    function automatic logic [1:0] corner_verdict(longint lx, longint ly, longint lz,
                                                  longint hx, longint hy, longint hz,
                                                  bit classify);
        longint v;
        bit     any_in;
        bit     any_out;
        bit     hit;
        any_out = 1'b0;
        for (int p = 0; p < PLANE_N; p++) begin
            any_in = 1'b0;
            for (int k = 0; k < 8; k++) begin
                v = plane_value(p, k[0] ? hx : lx, k[1] ? hy : ly, k[2] ? hz : lz);
                // first corner of a classify test counts a zero value as in
                hit = (classify && k == 0) ? (v >= 0) : (v > 0);
                if (hit)
                    any_in = 1'b1;
                else
                    any_out = 1'b1;
            end
            if (!any_in)
                return VERD_OUT;
        end
        return (classify && any_out) ? VERD_ISECT : VERD_IN;
    endfunction

    function automatic logic [1:0] cull_verdict(t_cull_req r);
        longint ax, ay, az, bx, by, bz, ext, limit;
        ax  = longint'($signed(r.ax));
        ay  = longint'($signed(r.ay));
        az  = longint'($signed(r.az));
        bx  = longint'($signed(r.bx));
        by  = longint'($signed(r.by));
        bz  = longint'($signed(r.bz));
        ext = longint'({1'b0, r.extent});
        case (r.cmd)
            CMD_POINT, CMD_SPHERE: begin
                limit = (r.cmd == CMD_POINT) ? 0 : -(ext * 256);
                for (int p = 0; p < PLANE_N; p++)
                    if (plane_value(p, ax, ay, az) <= limit)
                        return VERD_OUT;
                return VERD_IN;
            end
            CMD_CUBE:
                return corner_verdict(ax - ext, ay - ext, az - ext,
                                      ax + ext, ay + ext, az + ext, 1'b0);
            CMD_BOX:
                return corner_verdict(ax, ay, az, bx, by, bz, 1'b0);
            CMD_CLASSIFY:
                return corner_verdict(ax, ay, az, bx, by, bz, 1'b1);
            default:
                return VERD_OUT;
        endcase
    endfunction

    // ---------------------------------------------------------------- stimulus helpers

    function automatic t_cull_req mk(logic [2:0] cmd, logic [15:0] ax, logic [15:0] ay,
                                     logic [15:0] az, logic [15:0] bx, logic [15:0] by,
                                     logic [15:0] bz, logic [14:0] ext);
        t_cull_req r;
        r.cmd    = cmd;
        r.ax     = ax;
        r.ay     = ay;
        r.az     = az;
        r.bx     = bx;
        r.by     = by;
        r.bz     = bz;
        r.extent = ext;
        return r;
    endfunction

    function automatic logic [15:0] rand_coord(int scale);
        if ($urandom_range(0, 99) < 12)
            return 16'($urandom);
        return 16'(int'($urandom_range(0, 2 * scale)) - scale);
    endfunction

    function automatic t_cull_req random_req(int scale);
        t_cull_req r;
        if ($urandom_range(0, 9) == 0)
            r.cmd = 3'($urandom);
        else
            r.cmd = 3'($urandom_range(0, CMD_CLASSIFY));
        r.ax = rand_coord(scale);
        r.ay = rand_coord(scale);
        r.az = rand_coord(scale);
        r.bx = rand_coord(scale);
        r.by = rand_coord(scale);
        r.bz = rand_coord(scale);
        if ($urandom_range(0, 4) == 0)
            r.extent = 15'($urandom);
        else
            r.extent = 15'($urandom_range(0, scale / 2));
        return r;
    endfunction

    function automatic logic [63:0] pack_plane(logic [15:0] a, logic [15:0] b,
                                               logic [15:0] c, logic [15:0] d);
        return {d, c, b, a};
    endfunction

    function automatic logic [15:0] rand_coef();
        return 16'(int'($urandom_range(0, 512)) - 256);
    endfunction

    task automatic send(t_cull_req r);
        pending_reqs.push_back(r);
        issued_cnt++;
    endtask

    task automatic write_plane(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        if (idx < PLANE_N)
            planes[idx] = data;
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // Axis-aligned cube of half size w around the origin
    task automatic load_box_frustum(logic [15:0] w);
        write_plane(IDX_RIGHT,  pack_plane(Q_NEG_ONE, Q_ZERO, Q_ZERO, w));
        write_plane(IDX_LEFT,   pack_plane(Q_ONE, Q_ZERO, Q_ZERO, w));
        write_plane(IDX_BOTTOM, pack_plane(Q_ZERO, Q_ONE, Q_ZERO, w));
        write_plane(IDX_TOP,    pack_plane(Q_ZERO, Q_NEG_ONE, Q_ZERO, w));
        write_plane(IDX_FAR,    pack_plane(Q_ZERO, Q_ZERO, Q_NEG_ONE, w));
        write_plane(IDX_NEAR,   pack_plane(Q_ZERO, Q_ZERO, Q_ONE, w));
        setup_cnt++;
    endtask

    // Tilted planes with positive offsets, so the origin region stays visible
    task automatic load_oblique();
        for (int i = 0; i < PLANE_N; i++)
            write_plane(CFG_IDX_W'(i), pack_plane(rand_coef(), rand_coef(), rand_coef(),
                                                  16'($urandom_range(16'h0400, 16'h2000))));
        setup_cnt++;
    endtask

    // Wait until every transfer has been made and every verdict checked
    task automatic drain();
        while (accepted_cnt != issued_cnt || verdict_q.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic run_random(int n, int scale, int gpct, int spct);
        gap_pct   = gpct;
        stall_pct = spct;
        repeat (n) send(random_req(scale));
        drain();
    endtask

    // ---------------------------------------------------------------- input driver

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else if (in_if.valid && !in_taken) begin
            // hold the item until its transfer
        end else if (src_gap > 0) begin
            src_gap--;
            in_if.valid <= 1'b0;
        end else if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
            src_gap = $urandom_range(0, 11);
            in_if.valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
            drv_req = pending_reqs.pop_front();
            in_if.cmd    <= drv_req.cmd;
            in_if.ax     <= drv_req.ax;
            in_if.ay     <= drv_req.ay;
            in_if.az     <= drv_req.az;
            in_if.bx     <= drv_req.bx;
            in_if.by     <= drv_req.by;
            in_if.bz     <= drv_req.bz;
            in_if.extent <= drv_req.extent;
            in_if.valid  <= 1'b1;
        end else begin
            in_if.valid <= 1'b0;
        end
    end

    // Record each input transfer and predict its verdict
    always @(posedge i_clk) begin
        in_taken <= in_if.valid && in_if.ready;
        if (i_rst_n && in_if.valid && in_if.ready) begin
            verdict_q.push_back(cull_verdict(mk(in_if.cmd, in_if.ax, in_if.ay, in_if.az,
                                                in_if.bx, in_if.by, in_if.bz,
                                                in_if.extent)));
            accepted_cnt++;
        end
    end

    // ---------------------------------------------------------------- output side

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else if (sink_stall > 0) begin
            sink_stall--;
            out_if.ready <= 1'b0;
        end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
            sink_stall = $urandom_range(0, 11);
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    // Compare each verdict transfer with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (verdict_q.size() == 0) begin
                $error("verdict: expected none, actual %0d", out_if.verdict);
                fail_cnt++;
            end else begin
                if (out_if.verdict !== verdict_q[0]) begin
                    $error("verdict: expected %0d, actual %0d", verdict_q[0], out_if.verdict);
                    fail_cnt++;
                end
                if (verdict_q[0] <= VERD_ISECT)
                    verd_seen[verdict_q[0]]++;
                void'(verdict_q.pop_front());
                checked_cnt++;
            end
        end
    end

    // Cap the run length
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // ---------------------------------------------------------------- sequence

    initial begin
        i_rst_n      = 1'b0;
        cfg_we       = 1'b0;
        cfg_idx      = '0;
        cfg_data     = '0;
        in_if.valid  = 1'b0;
        in_if.cmd    = '0;
        in_if.ax     = '0;
        in_if.ay     = '0;
        in_if.az     = '0;
        in_if.bx     = '0;
        in_if.by     = '0;
        in_if.bz     = '0;
        in_if.extent = '0;
        out_if.ready = 1'b0;
        in_taken     = 1'b0;
        issued_cnt   = 0;
        accepted_cnt = 0;
        checked_cnt  = 0;
        fail_cnt     = 0;
        setup_cnt    = 1;
        cycle_cnt    = 0;
        src_gap      = 0;
        sink_stall   = 0;
        gap_pct      = 0;
        stall_pct    = 0;
        verd_seen    = '{0, 0, 0};
        for (int i = 0; i < PLANE_N; i++)
            planes[i] = '0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Planes still at reset: every value is zero
        send(mk(CMD_POINT,    16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 15'd0));
        send(mk(CMD_SPHERE,   16'h0100, 16'h0200, 16'h0300, 16'h0000, 16'h0000, 16'h0000, 15'd0));
        send(mk(CMD_SPHERE,   16'h0100, 16'h0200, 16'h0300, 16'h0000, 16'h0000, 16'h0000, 15'd1));
        send(mk(CMD_CLASSIFY, 16'h1234, 16'hF000, 16'h0042, 16'h8000, 16'h7FFF, 16'h0001, 15'd0));
        send(mk(CMD_CUBE,     16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 15'h7FFF));
        drain();

        // Cube frustum of half size 16.0; spare indexes must be ignored
        load_box_frustum(16'h1000);
        write_plane(IDX_SPARE6, {$urandom, $urandom});
        write_plane(IDX_SPARE7, {$urandom, $urandom});
        gap_pct   = 20;
        stall_pct = 20;
        send(mk(CMD_POINT,    16'h0000, 16'h0000, 16'h0000, 16'h7FFF, 16'h8000, 16'h7FFF, 15'h7FFF));
        send(mk(CMD_POINT,    16'h1000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 15'd0));
        send(mk(CMD_POINT,    16'h0FFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 15'd0));
        send(mk(CMD_POINT,    16'h8000, 16'h7FFF, 16'h8000, 16'h0000, 16'h0000, 16'h0000, 15'd0));
        send(mk(CMD_SPHERE,   16'h1400, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 15'h0400));
        send(mk(CMD_SPHERE,   16'h1400, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 15'h0401));
        send(mk(CMD_SPHERE,   16'h7FFF, 16'h8000, 16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 15'h7FFF));
        send(mk(CMD_CUBE,     16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 15'h0800));
        send(mk(CMD_CUBE,     16'h1800, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 15'h0800));
        send(mk(CMD_CUBE,     16'h17FF, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 15'h0800));
        send(mk(CMD_BOX,      16'hFC00, 16'hFC00, 16'hFC00, 16'h0400, 16'h0400, 16'h0400, 15'h7FFF));
        // reversed corners
        send(mk(CMD_BOX,      16'h0400, 16'h0400, 16'h0400, 16'hFC00, 16'hFC00, 16'hFC00, 15'd0));
        send(mk(CMD_BOX,      16'hE000, 16'h0000, 16'h0000, 16'hD000, 16'h0100, 16'h0100, 15'd0));
        send(mk(CMD_CLASSIFY, 16'hFC00, 16'hFC00, 16'hFC00, 16'h0400, 16'h0400, 16'h0400, 15'd0));
        send(mk(CMD_CLASSIFY, 16'h0800, 16'h0800, 16'h0800, 16'h1800, 16'h1800, 16'h1800, 15'd0));
        send(mk(CMD_CLASSIFY, 16'h2000, 16'h2000, 16'h2000, 16'h3000, 16'h3000, 16'h3000, 15'd0));
        // first corner exactly on the right plane, box flat on it
        send(mk(CMD_CLASSIFY, 16'h1000, 16'h0000, 16'h0000, 16'h1000, 16'h0100, 16'h0100, 15'd0));
        send(mk(CMD_BOX,      16'h1000, 16'h0000, 16'h0000, 16'h1000, 16'h0100, 16'h0100, 15'd0));
        send(mk(CMD_UNDEF5,   16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 15'h0100));
        send(mk(CMD_UNDEF6,   16'h0100, 16'h0100, 16'h0100, 16'h0200, 16'h0200, 16'h0200, 15'h0100));
        send(mk(CMD_UNDEF7,   16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 15'h7FFF));
        drain();

        run_random(250, 16'h2000, 20, 20);

        // Extreme coefficients
        write_plane(IDX_RIGHT,  pack_plane(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
        write_plane(IDX_LEFT,   pack_plane(16'h8000, 16'h8000, 16'h8000, 16'h7FFF));
        write_plane(IDX_BOTTOM, pack_plane(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF));
        write_plane(IDX_TOP,    pack_plane(16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF));
        write_plane(IDX_FAR,    pack_plane(16'h0000, 16'h0000, 16'h8000, 16'h7FFF));
        write_plane(IDX_NEAR,   pack_plane(16'h0000, 16'h0000, 16'h7FFF, 16'h8000));
        setup_cnt++;
        run_random(100, 16'h7FFF, 30, 30);

        load_oblique();
        run_random(250, 16'h1000, 0, 0);

        // Fully random plane words
        for (int i = 0; i < PLANE_N; i++)
            write_plane(CFG_IDX_W'(i), {$urandom, $urandom});
        setup_cnt++;
        run_random(100, 16'h4000, 15, 40);

        load_box_frustum(16'h7FFF);
        run_random(100, 16'h7FFF, 40, 10);

        // Closing stretch at full rate
        load_oblique();
        run_random(300, 16'h1000, 0, 0);

        repeat (2 * PIPE_LATENCY) @(negedge i_clk);

        $display("Checked %0d verdicts over %0d plane setups, all commands and undefined codes",
                 checked_cnt, setup_cnt);
        $display("Verdict mix: %0d outside, %0d inside, %0d intersecting",
                 verd_seen[0], verd_seen[1], verd_seen[2]);
        if (fail_cnt == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
